### rtl/sks_pkg.sv
// Shared types, constants and address helper for the sorted key search core
`timescale 1ns / 1ps
package sks_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int KEY_WIDTH   = 32;

	localparam int INDEX_BITS     = 10;
	localparam int KEY_VALUE_BITS = 32;
	localparam int COUNT_BITS     = 11;

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int NLEV  = $clog2(TABLE_DEPTH + 1);
	localparam int CNT_W = NLEV;

	typedef logic [KEY_WIDTH-1:0]  key_t;
	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [CNT_W-1:0]      cnt_t;
	typedef logic [COUNT_BITS-1:0] count_reg_t;

	typedef enum logic {
		FUNC_LOAD   = 1'b0,
		FUNC_SEARCH = 1'b1
	} func_t;

	typedef struct packed {
		func_t                     func;
		logic [INDEX_BITS-1:0]     entry_index;
		logic [KEY_VALUE_BITS-1:0] key_value;
	} cmd_t;

	typedef struct packed {
		logic                  found;
		logic [INDEX_BITS-1:0] match_index;
	} res_t;

	// word moving down the pipe: search or load
	typedef struct packed {
		logic valid;
		logic search;
		logic wr_ok;
		key_t target;
		cnt_t lo;
		idx_t addr;
	} item_t;

	// per-level search control, decoded from the key count
	typedef struct packed {
		logic active;
		logic first;
		cnt_t step;
	} lvl_ctl_t;

	// table address used by a word at one level
	function automatic idx_t probe_addr(input logic search, input idx_t addr_in,
			input cnt_t lo, input lvl_ctl_t c, input cnt_t count);
		idx_t a;
		if (!search) begin
			a = addr_in;
		end else if (c.first) begin
			a = IDX_W'(count - c.step);
		end else begin
			a = IDX_W'(lo + c.step - cnt_t'(1));
		end
		return a;
	endfunction

endpackage

### rtl/sks_level.sv
// One probe level: table copy, compare against the target, next probe address
`timescale 1ns / 1ps
module sks_level (
	input  logic              clk,
	input  logic              arst_n,
	input  sks_pkg::cnt_t     count,
	input  sks_pkg::lvl_ctl_t ctl,
	input  sks_pkg::lvl_ctl_t nxt_ctl,
	input  sks_pkg::item_t    issue,
	output sks_pkg::item_t    fwd
);

	sks_pkg::key_t  key_mem_q [sks_pkg::TABLE_DEPTH];
	sks_pkg::key_t  rdata_s1;
	sks_pkg::item_t stage_s1;
	logic           vld_s1;
	logic           gt;
	sks_pkg::cnt_t  lo_upd;

	// loads write this copy when they pass; searches read it
	always_ff @(posedge clk) begin
		if (issue.valid && !issue.search && issue.wr_ok) begin
			key_mem_q[issue.addr] <= issue.target;
		end
		if (issue.valid && issue.search) begin
			rdata_s1 <= key_mem_q[issue.addr];
		end
	end

	always_ff @(posedge clk) begin
		stage_s1 <= issue;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= issue.valid;
		end
	end

	// advance the lower bound past the probe when the target is greater
	assign gt     = stage_s1.search && ctl.active && (stage_s1.target > rdata_s1);
	assign lo_upd = gt ? (sks_pkg::cnt_t'(stage_s1.addr) + sks_pkg::cnt_t'(1)) : stage_s1.lo;

	always_comb begin
		fwd        = stage_s1;
		fwd.valid  = vld_s1;
		fwd.lo     = lo_upd;
		fwd.addr   = sks_pkg::probe_addr(stage_s1.search, stage_s1.addr, lo_upd, nxt_ctl, count);
	end

endmodule

### rtl/sks_match.sv
// Final stage: equality check at the lower bound and result register
`timescale 1ns / 1ps
module sks_match (
	input  logic           clk,
	input  logic           arst_n,
	input  sks_pkg::cnt_t  count,
	input  sks_pkg::item_t issue,
	output logic           done,
	output sks_pkg::res_t  result
);

	sks_pkg::key_t  key_mem_q [sks_pkg::TABLE_DEPTH];
	sks_pkg::key_t  rdata_s1;
	sks_pkg::item_t stage_s1;
	logic           vld_s1;
	logic           found;
	logic           done_q;
	sks_pkg::res_t  result_q;

	always_ff @(posedge clk) begin
		if (issue.valid && !issue.search && issue.wr_ok) begin
			key_mem_q[issue.addr] <= issue.target;
		end
		if (issue.valid && issue.search) begin
			rdata_s1 <= key_mem_q[issue.addr];
		end
	end

	always_ff @(posedge clk) begin
		stage_s1 <= issue;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= issue.valid;
			done_q <= vld_s1 && stage_s1.search;
		end
	end

	// a bound at the key count points past the table: drop the read data
	assign found = stage_s1.search && (stage_s1.lo < count) && (rdata_s1 == stage_s1.target);

	always_ff @(posedge clk) begin
		result_q.found       <= found;
		result_q.match_index <= found ? sks_pkg::INDEX_BITS'(stage_s1.lo) : '0;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

### rtl/sorted_key_exact_search_core.sv
// Top level of the sorted key exact search core
// Path: a search passes the probe levels in order, then the final compare and
//   the result register, which raises the result strobe.
// Throughput: one word per cycle, loads and searches mixed; busy stays low.
// Each probe level owns its own table copy, so every level reads in the same cycle.
// Reset clears the key count, the stage valid bits and the strobe; table contents
//   are undefined until loaded.
`timescale 1ns / 1ps
module sorted_key_exact_search_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  sks_pkg::cmd_t         cmd,
	input  logic                  key_count_wr,
	input  sks_pkg::count_reg_t   key_count_data,
	output logic                  done,
	output sks_pkg::res_t         result
);

	localparam int LAT = sks_pkg::NLEV + 2;

	sks_pkg::count_reg_t key_count_q;
	sks_pkg::cnt_t       count_sat;
	sks_pkg::lvl_ctl_t   ctl   [sks_pkg::NLEV+1];
	sks_pkg::item_t      issue [sks_pkg::NLEV+1];
	sks_pkg::item_t      head_item;
	logic                accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q <= '0;
		end else if (key_count_wr) begin
			key_count_q <= key_count_data;
		end
	end

	assign count_sat = (32'(key_count_q) > 32'(sks_pkg::TABLE_DEPTH))
		? sks_pkg::CNT_W'(sks_pkg::TABLE_DEPTH) : sks_pkg::CNT_W'(key_count_q);

	// a level is active once its step fits in the count; the top set bit marks the first
	always_comb begin
		for (int k = 0; k < sks_pkg::NLEV; k++) begin
			ctl[k].step   = sks_pkg::cnt_t'(1) << (sks_pkg::NLEV - 1 - k);
			ctl[k].active = (count_sat >> (sks_pkg::NLEV - 1 - k)) != '0;
			ctl[k].first  = ctl[k].active && ((count_sat >> (sks_pkg::NLEV - k)) == '0);
		end
		ctl[sks_pkg::NLEV].active = 1'b1;
		ctl[sks_pkg::NLEV].first  = 1'b0;
		ctl[sks_pkg::NLEV].step   = sks_pkg::cnt_t'(1);
	end

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_comb begin
		head_item.valid  = accept;
		head_item.search = (cmd.func == sks_pkg::FUNC_SEARCH);
		head_item.wr_ok  = 32'(cmd.entry_index) < 32'(sks_pkg::TABLE_DEPTH);
		head_item.target = sks_pkg::key_t'(cmd.key_value);
		head_item.lo     = '0;
		head_item.addr   = sks_pkg::probe_addr(head_item.search,
			sks_pkg::IDX_W'(cmd.entry_index), '0, ctl[0], count_sat);
	end

	assign issue[0] = head_item;

	for (genvar k = 0; k < sks_pkg::NLEV; k++) begin : g_lvl
		sks_level u_lvl (
			.clk     (clk),
			.arst_n  (arst_n),
			.count   (count_sat),
			.ctl     (ctl[k]),
			.nxt_ctl (ctl[k+1]),
			.issue   (issue[k]),
			.fwd     (issue[k+1])
		);
	end

	sks_match u_match (
		.clk    (clk),
		.arst_n (arst_n),
		.count  (count_sat),
		.issue  (issue[sks_pkg::NLEV]),
		.done   (done),
		.result (result)
	);

	a_done_from_search: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept && (cmd.func == sks_pkg::FUNC_SEARCH), LAT))
		else $error("result strobe without a matching search");

	a_search_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (cmd.func == sks_pkg::FUNC_SEARCH) |-> ##(LAT) done)
		else $error("search produced no result");

	a_miss_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.found |-> result.match_index == '0)
		else $error("miss reported with nonzero index");

	a_hit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.found |-> 32'(result.match_index) < 32'(count_sat))
		else $error("hit index beyond key count");

endmodule

### dv/sks_lookup_checker.sv
// Checker for the sorted key search core: tracks table and key count, predicts and compares
`timescale 1ns / 1ps
module sks_lookup_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                busy,
	input  sks_pkg::cmd_t       cmd,
	input  logic                key_count_wr,
	input  sks_pkg::count_reg_t key_count_data,
	input  logic                done,
	input  sks_pkg::res_t       result,
	output int                  pending,
	output int                  mismatches
);
	import sks_pkg::*;

	key_t       key_image [TABLE_DEPTH];
	count_reg_t key_count_shadow;
	res_t       expected_hits [$];
	int         err_total;

	initial begin
		pending    = 0;
		mismatches = 0;
		err_total  = 0;
	end

	// balanced lower-bound walk, then an equality check at the bound
	function automatic res_t lower_bound_lookup(key_t target);
		int   n;
		int   levels;
		int   stride;
		int   probe;
		int   lo;
		int   alt;
		res_t r;
		r = '0;
		n = (key_count_shadow > TABLE_DEPTH) ? TABLE_DEPTH : int'(key_count_shadow);
		if (n == 0)
			return r;
		levels = 0;
		while ((1 << levels) < n + 1)
			levels++;
		stride = 1 << (levels - 1);
		probe  = n - stride;
		stride = stride >> 1;
		lo     = 0;
		alt    = probe + 1;
		while (levels > 0) begin
			levels--;
			if (target > key_image[probe])
				lo = alt;
			alt    = lo + stride;
			probe  = lo + stride - 1;
			stride = stride >> 1;
		end
		if (lo < n && key_image[lo] == target) begin
			r.found       = 1'b1;
			r.match_index = lo[INDEX_BITS-1:0];
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		res_t want;
		if (!arst_n) begin
			key_count_shadow = '0;
			expected_hits.delete();
			pending <= 0;
		end else begin
			if (key_count_wr)
				key_count_shadow = key_count_data;
			if (start && !busy) begin
				if (cmd.func == FUNC_LOAD)
					key_image[cmd.entry_index] = cmd.key_value;
				else
					expected_hits.push_back(lower_bound_lookup(cmd.key_value));
			end
			if (done) begin
				if (expected_hits.size() == 0) begin
					$display("%0t: unexpected result word, expected none, got found=%0b index=%0d",
						$time, result.found, result.match_index);
					err_total++;
				end else begin
					want = expected_hits.pop_front();
					if (result.found !== want.found) begin
						$display("%0t: found mismatch, expected %0b, got %0b",
							$time, want.found, result.found);
						err_total++;
					end
					if (result.match_index !== want.match_index) begin
						$display("%0t: match_index mismatch, expected %0d, got %0d",
							$time, want.match_index, result.match_index);
						err_total++;
					end
				end
			end
			pending    <= expected_hits.size();
			mismatches <= err_total;
		end
	end

endmodule

### dv/testbench.sv
// Stimulus and verdict for the sorted key exact search core
`timescale 1ns / 1ps
module testbench;
	import sks_pkg::*;

	localparam int SETTLE_CYCLES  = NLEV + 3;
	localparam int WATCHDOG_LIMIT = 2000;

	logic       clk            = 1'b0;
	logic       arst_n         = 1'b0;
	logic       start          = 1'b0;
	cmd_t       cmd            = '0;
	logic       key_count_wr   = 1'b0;
	count_reg_t key_count_data = '0;
	logic       busy;
	logic       done;
	res_t       result;
	int         pending;
	int         mismatches;

	key_t loaded_keys [TABLE_DEPTH];
	bit   loaded [TABLE_DEPTH];
	int   filled_upto     = 0;
	int   items_sent      = 0;
	int   sender_idle_pct = 0;
	int   idle_cycles     = 0;

	sorted_key_exact_search_core uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.cmd            (cmd),
		.key_count_wr   (key_count_wr),
		.key_count_data (key_count_data),
		.done           (done),
		.result         (result)
	);

	sks_lookup_checker lookup_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.cmd            (cmd),
		.key_count_wr   (key_count_wr),
		.key_count_data (key_count_data),
		.done           (done),
		.result         (result),
		.pending        (pending),
		.mismatches     (mismatches)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic send_word(func_t f, logic [INDEX_BITS-1:0] idx, key_t k);
		cmd_t c;
		if (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		c.func        = f;
		c.entry_index = idx;
		c.key_value   = k;
		cmd   <= c;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		items_sent++;
		if (f == FUNC_LOAD) begin
			loaded_keys[idx] = k;
			loaded[idx]      = 1'b1;
			while (filled_upto < TABLE_DEPTH && loaded[filled_upto])
				filled_upto++;
		end
	endtask

	// hold off until every search has answered and loads have left the pipe
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_count(int n);
		drain();
		key_count_data <= count_reg_t'(n);
		key_count_wr   <= 1'b1;
		@(posedge clk);
		key_count_wr   <= 1'b0;
	endtask

	// ascending keys into the first m entries, duplicates likely with a tight spread
	task automatic fill_sorted(int m);
		longint      k;
		int unsigned spread;
		int          i;
		case ($urandom_range(0, 2))
			0:       spread = 3;
			1:       spread = 200;
			default: spread = 32'hFFFF_FFFF / (m + 1);
		endcase
		case ($urandom_range(0, 9))
			0:       k = 0;
			1:       k = 64'hFFFF_FF00;
			default: k = $urandom_range(0, 5000);
		endcase
		for (i = 0; i < m; i++) begin
			send_word(FUNC_LOAD, INDEX_BITS'(i), key_t'(k));
			k = k + $urandom_range(0, spread);
			if (k > 64'hFFFF_FFFF)
				k = 64'hFFFF_FFFF;
		end
	endtask

	function automatic key_t next_target(int m);
		int   r;
		key_t k;
		r = $urandom_range(0, 99);
		if (m == 0 || r >= 85) begin
			k = $urandom;
		end else begin
			k = loaded_keys[$urandom_range(0, m - 1)];
			if (r >= 55 && r < 70)
				k = k + 1'b1;
			else if (r >= 70 && r < 78)
				k = k - 1'b1;
			else if (r >= 78)
				k = $urandom_range(0, 1) ? '0 : '1;
		end
		return k;
	endfunction

	// searches over the first m entries, with stray loads mixed in
	task automatic run_searches(int m, int num);
		int i;
		for (i = 0; i < num; i++) begin
			if ($urandom_range(0, 99) < 12)
				send_word(FUNC_LOAD, INDEX_BITS'($urandom_range(0, TABLE_DEPTH - 1)), $urandom);
			else
				send_word(FUNC_SEARCH, INDEX_BITS'($urandom), next_target(m));
			if ($urandom_range(0, 99) < 3)
				drain();
		end
	endtask

	initial begin : stimulus
		int idle_plan [4];
		int phase;
		int n;
		idle_plan = '{0, 55, 25, 55};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// empty table: searches with a zero key count must miss
		set_count(0);
		send_word(FUNC_SEARCH, '0, '0);
		send_word(FUNC_SEARCH, '1, '1);
		send_word(FUNC_LOAD, 10'd0, 32'd0);
		send_word(FUNC_LOAD, 10'd1, 32'd5);
		send_word(FUNC_LOAD, 10'd2, 32'd5);
		send_word(FUNC_LOAD, 10'd3, 32'hFFFF_FFFF);
		send_word(FUNC_LOAD, 10'd1023, 32'hA5A5_A5A5);
		set_count(4);
		send_word(FUNC_SEARCH, '0, 32'd0);
		send_word(FUNC_SEARCH, '0, 32'd5);
		send_word(FUNC_SEARCH, '0, 32'd4);
		send_word(FUNC_SEARCH, '0, 32'd6);
		send_word(FUNC_SEARCH, '0, 32'hFFFF_FFFF);
		send_word(FUNC_SEARCH, '0, 32'hFFFF_FFFE);
		set_count(1);
		send_word(FUNC_SEARCH, '0, 32'd0);
		send_word(FUNC_SEARCH, '0, 32'd1);
		// break the ordering
		send_word(FUNC_LOAD, 10'd1, 32'd9);
		set_count(4);
		send_word(FUNC_SEARCH, '0, 32'd5);
		send_word(FUNC_SEARCH, '0, 32'd9);

		phase = 0;
		while (items_sent < 150) begin
			phase++;
			sender_idle_pct = idle_plan[phase % 4];
			if (filled_upto > 0 && $urandom_range(0, 9) < 4) begin
				n = $urandom_range(0, filled_upto);
			end else begin
				case ($urandom_range(0, 9))
					0:       n = 0;
					1:       n = 1;
					2:       n = $urandom_range(2, 3);
					3, 4:    n = $urandom_range(64, 200);
					default: n = $urandom_range(4, 63);
				endcase
				fill_sorted(n);
			end
			set_count(n);
			run_searches(n, $urandom_range(15, 50));
		end

		// full table, then counts at, beyond and just below the depth
		sender_idle_pct = 25;
		fill_sorted(TABLE_DEPTH);
		set_count(TABLE_DEPTH);
		run_searches(TABLE_DEPTH, 50);
		sender_idle_pct = 0;
		set_count(2047);
		run_searches(TABLE_DEPTH, 40);
		sender_idle_pct = 55;
		set_count($urandom_range(TABLE_DEPTH + 1, 2046));
		run_searches(TABLE_DEPTH, 30);
		set_count(TABLE_DEPTH - 1);
		run_searches(TABLE_DEPTH - 1, 30);

		drain();
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
